### rtl/cdq_pkg.sv
`default_nettype none

package cdq_pkg;

  // Request codes carried in req_type.
  localparam logic [1:0] REQ_PUSH_FRONT = 2'd0;
  localparam logic [1:0] REQ_PUSH_REAR  = 2'd1;
  localparam logic [1:0] REQ_POP_FRONT  = 2'd2;
  localparam logic [1:0] REQ_POP_REAR   = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] pop_value;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic exec;
    logic load_out;
  } cdq_cmd_t;

endpackage

`default_nettype wire

### rtl/cdq_ctrl.sv
`default_nettype none

module cdq_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output cdq_pkg::cdq_cmd_t     cmd
);
  import cdq_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  // The output register can take a new item when it is empty or being drained.
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt    = state_r;
    cmd.capture  = 1'b0;
    cmd.exec     = 1'b0;
    cmd.load_out = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/cdq_datapath.sv
`default_nettype none

module cdq_datapath #(
  parameter int DEPTH = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cdq_pkg::cdq_cmd_t  cmd,
  input  wire cdq_pkg::in_item_t  in_data,
  output cdq_pkg::out_item_t      out_data
);
  import cdq_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [PTR_W-1:0] ZERO = '0;
  localparam logic [PTR_W-1:0] ONE  = PTR_W'(1);

  logic signed [31:0] mem [DEPTH];

  logic [1:0]         req_r;
  logic signed [31:0] val_r;
  logic [PTR_W-1:0]   head_r, head_nxt;
  logic [PTR_W-1:0]   tail_r, tail_nxt;
  logic               empty_r, empty_nxt;
  logic [1:0]         status_r, status_nxt;
  logic               pop_ok_r, pop_ok_nxt;
  logic signed [31:0] rd_data_r;
  out_item_t          out_r;

  logic               is_pop, is_front, full, we;
  logic [PTR_W-1:0]   waddr, raddr;
  logic [PTR_W-1:0]   tail_inc, head_inc, head_dec, tail_dec;

  assign tail_inc = (tail_r == LAST) ? ZERO : tail_r + ONE;
  assign head_inc = (head_r == LAST) ? ZERO : head_r + ONE;
  assign head_dec = (head_r == ZERO) ? LAST : head_r - ONE;
  assign tail_dec = (tail_r == ZERO) ? LAST : tail_r - ONE;
  assign full     = !empty_r && (tail_inc == head_r);

  always_comb begin
    is_pop   = 1'b0;
    is_front = 1'b0;
    unique case (req_r)
      REQ_PUSH_FRONT: is_front = 1'b1;
      REQ_PUSH_REAR:  is_front = 1'b0;
      REQ_POP_FRONT: begin
        is_pop   = 1'b1;
        is_front = 1'b1;
      end
      REQ_POP_REAR:   is_pop = 1'b1;
      default:        is_pop = 1'b0;
    endcase
  end

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    empty_nxt  = empty_r;
    status_nxt = ST_OK;
    pop_ok_nxt = 1'b0;
    we         = 1'b0;
    waddr      = ZERO;
    raddr      = is_front ? head_r : tail_r;
    if (!is_pop) begin
      if (empty_r) begin
        head_nxt  = ZERO;
        tail_nxt  = ZERO;
        empty_nxt = 1'b0;
        we        = 1'b1;
      end else if (full) begin
        status_nxt = ST_OVERFLOW;
      end else if (is_front) begin
        head_nxt = head_dec;
        waddr    = head_dec;
        we       = 1'b1;
      end else begin
        tail_nxt = tail_inc;
        waddr    = tail_inc;
        we       = 1'b1;
      end
    end else begin
      if (empty_r) begin
        status_nxt = ST_UNDERFLOW;
      end else begin
        pop_ok_nxt = 1'b1;
        if (head_r == tail_r) begin
          head_nxt  = ZERO;
          tail_nxt  = ZERO;
          empty_nxt = 1'b1;
        end else if (is_front) begin
          head_nxt = head_inc;
        end else begin
          tail_nxt = tail_dec;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= ZERO;
      tail_r  <= ZERO;
      empty_r <= 1'b1;
    end else if (cmd.exec) begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      empty_r <= empty_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_data.req_type;
      val_r <= in_data.push_value;
    end
    if (cmd.exec) begin
      status_r <= status_nxt;
      pop_ok_r <= pop_ok_nxt;
    end
    if (cmd.load_out) begin
      out_r.status    <= status_r;
      out_r.pop_value <= pop_ok_r ? rd_data_r : 32'sd0;
    end
  end

  // Store: at most one write and one registered read per request.
  always_ff @(posedge clk) begin
    if (cmd.exec && we) begin
      mem[waddr] <= val_r;
    end
    if (cmd.exec) begin
      rd_data_r <= mem[raddr];
    end
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

### rtl/circular_deque_core.sv
`default_nettype none
// An accepted request is captured, then executed against the pointers and the store
// (with a registered read), then loaded into the output register once that is free.
// A new request is taken only after the previous result has been loaded; in_stall
// stays high from capture until that output load.
// Reset (synchronous, active low) empties the deque and zeroes both pointers;
// store contents stay undefined and need no clearing pass.

module circular_deque_core #(
  parameter int DEPTH = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire cdq_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output cdq_pkg::out_item_t      out_data
);
  import cdq_pkg::*;

  // The controller sequences each item through capture, execute and
  // output load; the datapath holds pointers, the store and the result register.
  cdq_cmd_t cmd;

  cdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // The execute step updates the pointers, writes the store on a successful push
  // and always reads the entry at the front or rear end into a register.
  cdq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

### dv/tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the circular double-ended queue. Requests go in over a
// valid/stall channel, one item per handshake, and each one is predicted the moment
// the block accepts it. Results are checked in order against the oldest prediction.
module tb;
  import cdq_pkg::*;

  localparam int DEPTH = 8;
  localparam int PTR_W = $clog2(DEPTH);
  // A short settle window at the end is enough to catch any stray result.
  localparam int SETTLE_CYCLES = 12;
  localparam int MAX_WAIT = 17;

  typedef logic [PTR_W-1:0] ptr_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  circular_deque_core #(.DEPTH(DEPTH)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Shadow copy of the deque. Only entries that a predicted push wrote are ever
  // read back, so the stimulus can never pop a word the block never stored.
  logic signed [31:0] shadow_store [DEPTH];
  ptr_t               front_ptr;
  ptr_t               rear_ptr;
  bit                 deque_empty;

  out_item_t pending_results [$];
  int        fail_count;
  // When set, neither side idles; used for back-to-back stretches.
  bit        idle_off;

  function automatic ptr_t ptr_next(ptr_t p);
    return (p == ptr_t'(DEPTH - 1)) ? ptr_t'(0) : ptr_t'(p + 1);
  endfunction

  function automatic ptr_t ptr_prev(ptr_t p);
    return (p == ptr_t'(0)) ? ptr_t'(DEPTH - 1) : ptr_t'(p - 1);
  endfunction

  // Advances the shadow deque by one request and returns the result it must give.
  function automatic out_item_t apply_deque_request(in_item_t req);
    out_item_t res;
    res.status    = ST_OK;
    res.pop_value = '0;
    if (req.req_type == REQ_PUSH_FRONT || req.req_type == REQ_PUSH_REAR) begin
      if (deque_empty) begin
        // A push into an empty deque always lands in entry zero.
        front_ptr       = '0;
        rear_ptr        = '0;
        shadow_store[0] = req.push_value;
        deque_empty     = 1'b0;
      end else if (ptr_next(rear_ptr) == front_ptr) begin
        res.status = ST_OVERFLOW;
      end else if (req.req_type == REQ_PUSH_FRONT) begin
        front_ptr               = ptr_prev(front_ptr);
        shadow_store[front_ptr] = req.push_value;
      end else begin
        rear_ptr               = ptr_next(rear_ptr);
        shadow_store[rear_ptr] = req.push_value;
      end
    end else begin
      if (deque_empty) begin
        res.status = ST_UNDERFLOW;
      end else begin
        res.pop_value = shadow_store[(req.req_type == REQ_POP_FRONT) ? front_ptr : rear_ptr];
        if (front_ptr == rear_ptr) begin
          // Last element gone: the pointers fall back to zero.
          front_ptr   = '0;
          rear_ptr    = '0;
          deque_empty = 1'b1;
        end else if (req.req_type == REQ_POP_FRONT) begin
          front_ptr = ptr_next(front_ptr);
        end else begin
          rear_ptr = ptr_prev(rear_ptr);
        end
      end
    end
    return res;
  endfunction

  function automatic int draw_wait();
    if (idle_off) return 0;
    // At least a quarter of the draws are zero so short bursts appear even in idle mode.
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic logic signed [31:0] pick_word();
    case ($urandom_range(0, 5))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return 32'sh0000_0000;
      3:       return 32'shffff_ffff;
      default: return $signed($urandom);
    endcase
  endfunction

  // Sends one item. It is always entered right after a rising edge, either the
  // edge that accepted the previous item or one the bench idled on, so in_valid
  // gets exactly one assignment per time step and stays high across back-to-back
  // items.
  task automatic send_request(input logic [1:0] kind, input logic signed [31:0] word);
    int       gap;
    in_item_t req;
    gap            = draw_wait();
    req.req_type   = kind;
    req.push_value = word;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    // Accepted at the first edge where in_stall was low with valid high.
    do @(posedge clk); while (in_stall);
    pending_results.push_back(apply_deque_request(req));
  endtask

  // Stops sending and waits until every predicted result has come back. At least
  // one edge passes, so the next item starts in a later time step.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic send_random_request(input int push_pct);
    bit         is_pop;
    bit         at_front;
    logic [1:0] kind;
    is_pop   = ($urandom_range(0, 99) >= push_pct);
    at_front = ($urandom_range(0, 1) == 1);
    if (is_pop) kind = at_front ? REQ_POP_FRONT : REQ_POP_REAR;
    else        kind = at_front ? REQ_PUSH_FRONT : REQ_PUSH_REAR;
    // Pops carry a random word too; the block must ignore it.
    send_request(kind, pick_word());
  endtask

  // Both ends of an empty deque underflow.
  task automatic test_empty_pops();
    send_request(REQ_POP_FRONT, 32'sh1234_5678);
    send_request(REQ_POP_REAR, 32'shffff_ffff);
  endtask

  // Fill the deque from the front so the front pointer wraps below zero, then
  // check that pushes at either end overflow without touching the contents.
  task automatic test_fill_and_overflow();
    send_request(REQ_PUSH_FRONT, 32'sh7fff_ffff);
    send_request(REQ_PUSH_FRONT, 32'sh8000_0000);
    send_request(REQ_PUSH_FRONT, 32'sh0000_0000);
    send_request(REQ_PUSH_FRONT, 32'shffff_ffff);
    send_request(REQ_PUSH_FRONT, 32'sh5555_5555);
    send_request(REQ_PUSH_FRONT, 32'shaaaa_aaaa);
    send_request(REQ_PUSH_FRONT, 32'sh0000_0001);
    send_request(REQ_PUSH_FRONT, 32'sh8000_0001);
    send_request(REQ_PUSH_REAR, 32'sh0bad_cafe);
    send_request(REQ_PUSH_FRONT, 32'sh7fff_fffe);
  endtask

  // Empty the full deque from alternating ends, then pop once more.
  task automatic test_drain_both_ends();
    for (int i = 0; i < DEPTH; i++) begin
      send_request((i % 2 == 0) ? REQ_POP_REAR : REQ_POP_FRONT, pick_word());
    end
    send_request(REQ_POP_FRONT, 32'sh0000_0000);
  endtask

  // One element pushed into an empty deque and popped from the other end, each way.
  task automatic test_single_element();
    send_request(REQ_PUSH_REAR, 32'shdead_beef);
    send_request(REQ_POP_FRONT, 32'sh0000_0000);
    send_request(REQ_PUSH_FRONT, 32'sh8000_0000);
    send_request(REQ_POP_REAR, 32'sh7fff_ffff);
  endtask

  // Full-rate traffic with neither side idling.
  task automatic test_back_to_back(input int count);
    idle_off = 1'b1;
    for (int i = 0; i < count; i++) begin
      send_random_request((i < count / 2) ? 70 : 35);
    end
    idle_off = 1'b0;
  endtask

  // Segments biased toward pushing, popping or neither drive the deque between full and
  // empty again and again; some segments run without idling, and every fifth one
  // is followed by a pause until all results are back.
  task automatic test_random_traffic(input int count);
    int sent;
    int seg;
    int seg_len;
    int push_pct;
    sent = 0;
    seg  = 0;
    while (sent < count) begin
      seg_len = $urandom_range(10, 40);
      case ($urandom_range(0, 2))
        0:       push_pct = 80;
        1:       push_pct = 20;
        default: push_pct = 50;
      endcase
      idle_off = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < seg_len && sent < count; i++) begin
        send_random_request(push_pct);
        sent++;
      end
      if (seg % 5 == 2) wait_for_results();
      seg++;
    end
    idle_off = 1'b0;
  endtask

  // Result side: stall for a random number of cycles before each result, then
  // take it and compare it with the oldest prediction.
  initial begin
    out_item_t want;
    int        gap;
    out_stall <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      gap = draw_wait();
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      if (pending_results.size() == 0) begin
        $error("result with no request waiting: status %0d, pop_value %0d",
               out_data.status, out_data.pop_value);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, out_data.status);
          fail_count++;
        end
        if (out_data.pop_value !== want.pop_value) begin
          $error("pop_value mismatch: expected %0d, actual %0d",
                 want.pop_value, out_data.pop_value);
          fail_count++;
        end
      end
    end
  end

  initial begin
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_data     <= '0;
    idle_off     = 1'b0;
    fail_count   = 0;
    front_ptr    = '0;
    rear_ptr     = '0;
    deque_empty  = 1'b1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_pops();
    test_fill_and_overflow();
    test_drain_both_ends();
    test_single_element();
    wait_for_results();
    test_back_to_back(60);
    test_random_traffic(390);
    wait_for_results();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: fails the run if it has not finished within a generous time bound.
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
